/* src/irc_tag_pkg.sv */
// Package for the IRC message field tagger: parse phases, field tags,
// character constants and the result record shared by the parser and top level.
// No dependencies.
`default_nettype none

package irc_tag_pkg;

   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_BANG  = 8'h21;
   localparam logic [7:0] CHAR_AT    = 8'h40;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   typedef enum logic [3:0] {
      PH_LINE_START  = 4'd0,
      PH_PREFIX_HEAD = 4'd1,
      PH_USER        = 4'd2,
      PH_HOST        = 4'd3,
      PH_CMD_WAIT    = 4'd4,
      PH_CMD         = 4'd5,
      PH_PARAM_WAIT  = 4'd6,
      PH_MIDDLE      = 4'd7,
      PH_TRAILING    = 4'd8
   } phase_type;

   typedef enum logic [2:0] {
      TAG_SEP    = 3'd0,
      TAG_HEAD   = 3'd1,
      TAG_USER   = 3'd2,
      TAG_HOST   = 3'd3,
      TAG_CMD    = 3'd4,
      TAG_MIDDLE = 3'd5,
      TAG_TRAIL  = 3'd6
   } field_tag_type;

   localparam logic [1:0] KIND_NONE   = 2'd0;
   localparam logic [1:0] KIND_SERVER = 2'd1;
   localparam logic [1:0] KIND_NUH    = 2'd2;

   typedef struct packed {
      logic [7:0]    byte_out;
      field_tag_type field_tag;
      logic          token_start;
      logic [3:0]    param_index;
      logic [1:0]    prefix_kind;
      logic          prefix_done;
      logic          malformed;
      logic          last_out;
   } result_type;

endpackage

`default_nettype wire

/* src/irc_tag_parse.sv */
// Parser core of the IRC message field tagger: line state registers and the
// per-byte tagging logic. Depends on irc_tag_pkg.
`default_nettype none

module irc_tag_parse #(
   parameter int MAX_PARAMS = 15
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   step,
   input  wire logic [7:0]             line_byte,
   input  wire logic                   line_end,
   output irc_tag_pkg::result_type     result
);
   import irc_tag_pkg::*;

   localparam logic [3:0] ParamCap = (MAX_PARAMS < 15) ? 4'(MAX_PARAMS) : 4'd15;

   phase_type  phase_ff, phase_in;
   logic       seen_bang_ff, seen_bang_in;
   logic [3:0] count_ff, count_in;
   logic       in_token_ff, in_token_in;
   logic       cmd_seen_ff, cmd_seen_in;

   logic is_space;
   logic is_colon;

   assign is_space  = (line_byte == CHAR_SPACE);
   assign is_colon  = (line_byte == CHAR_COLON);

   // Next-state logic.
   always_comb begin
      phase_in     = phase_ff;
      seen_bang_in = seen_bang_ff;
      count_in     = count_ff;
      in_token_in  = in_token_ff;
      cmd_seen_in  = cmd_seen_ff;
      unique case (phase_ff)
         PH_PREFIX_HEAD, PH_USER, PH_HOST: begin
            if (is_space) begin
               phase_in    = PH_CMD_WAIT;
               in_token_in = 1'b0;
            end else if (phase_ff == PH_PREFIX_HEAD && line_byte == CHAR_BANG) begin
               seen_bang_in = 1'b1;
               phase_in     = PH_USER;
               in_token_in  = 1'b0;
            end else if (phase_ff == PH_USER && line_byte == CHAR_AT) begin
               phase_in    = PH_HOST;
               in_token_in = 1'b0;
            end else begin
               in_token_in = 1'b1;
            end
         end
         PH_CMD: begin
            if (is_space) begin
               phase_in    = PH_PARAM_WAIT;
               in_token_in = 1'b0;
            end
         end
         PH_PARAM_WAIT: begin
            if (is_space) begin
               phase_in = PH_PARAM_WAIT;
            end else if (is_colon) begin
               phase_in    = PH_TRAILING;
               in_token_in = 1'b0;
            end else begin
               phase_in    = PH_MIDDLE;
               in_token_in = 1'b1;
            end
         end
         PH_MIDDLE: begin
            if (is_space) begin
               if (count_ff < ParamCap) begin
                  count_in = count_ff + 4'd1;
               end
               phase_in    = PH_PARAM_WAIT;
               in_token_in = 1'b0;
            end
         end
         PH_TRAILING: begin
            in_token_in = 1'b1;
         end
         default: begin
            // Line start and waiting for the command; only a colon as the
            // very first byte opens a prefix.
            if (phase_ff == PH_LINE_START && is_colon) begin
               phase_in    = PH_PREFIX_HEAD;
               in_token_in = 1'b0;
            end else if (is_space) begin
               phase_in    = PH_CMD_WAIT;
               in_token_in = 1'b0;
            end else begin
               cmd_seen_in = 1'b1;
               phase_in    = PH_CMD;
               in_token_in = 1'b1;
            end
         end
      endcase
      if (line_end) begin
         phase_in     = PH_LINE_START;
         seen_bang_in = 1'b0;
         count_in     = 4'd0;
         in_token_in  = 1'b0;
         cmd_seen_in  = 1'b0;
      end
   end

   // Output logic.
   always_comb begin
      result             = '0;
      result.byte_out    = line_byte;
      result.field_tag   = TAG_SEP;
      result.last_out    = line_end;
      result.prefix_kind = KIND_NONE;
      unique case (phase_ff)
         PH_PREFIX_HEAD, PH_USER, PH_HOST: begin
            if (is_space) begin
               result.prefix_done = 1'b1;
               result.prefix_kind = seen_bang_ff ? KIND_NUH : KIND_SERVER;
            end else if (!(phase_ff == PH_PREFIX_HEAD && line_byte == CHAR_BANG) &&
                         !(phase_ff == PH_USER && line_byte == CHAR_AT)) begin
               result.field_tag   = (phase_ff == PH_PREFIX_HEAD) ? TAG_HEAD :
                                    (phase_ff == PH_USER) ? TAG_USER : TAG_HOST;
               result.token_start = !in_token_ff;
            end
         end
         PH_CMD: begin
            if (!is_space) begin
               result.field_tag = TAG_CMD;
            end
         end
         PH_PARAM_WAIT: begin
            if (!is_space && !is_colon) begin
               result.field_tag   = TAG_MIDDLE;
               result.token_start = 1'b1;
               result.param_index = count_ff;
            end
         end
         PH_MIDDLE: begin
            if (!is_space) begin
               result.field_tag   = TAG_MIDDLE;
               result.param_index = count_ff;
            end
         end
         PH_TRAILING: begin
            result.field_tag   = TAG_TRAIL;
            result.token_start = !in_token_ff;
         end
         default: begin
            if (!(phase_ff == PH_LINE_START && is_colon) && !is_space) begin
               result.field_tag   = TAG_CMD;
               result.token_start = 1'b1;
            end
         end
      endcase
      // A command byte that is itself the last byte of the line also counts.
      result.malformed = line_end && !(cmd_seen_ff || (result.field_tag == TAG_CMD));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_LINE_START;
         seen_bang_ff <= 1'b0;
         count_ff     <= 4'd0;
         in_token_ff  <= 1'b0;
         cmd_seen_ff  <= 1'b0;
      end else if (step) begin
         phase_ff     <= phase_in;
         seen_bang_ff <= seen_bang_in;
         count_ff     <= count_in;
         in_token_ff  <= in_token_in;
         cmd_seen_ff  <= cmd_seen_in;
      end
   end

endmodule

`default_nettype wire

/* src/irc_message_field_tagger_top.sv */
// Top level of the IRC message field tagger: input request register, parser
// core and result register. Depends on irc_tag_pkg and irc_tag_parse.
// An accepted request is held in the input register, tagged by the parser and then
// captured in the result register once the output is free.
// Throughput: one byte per cycle while rsp_tready does not stall the output.
// Reset clears both register stages and returns the parser to line start.
`default_nettype none

module irc_message_field_tagger_top #(
   parameter int MAX_PARAMS = 15
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] line_byte
   input  wire logic        req_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // [7:0] byte_out, [8] token_start,
                                         // [12:9] param_index, [14:13] prefix_kind,
                                         // [15] prefix_done, [16] malformed, zero above
   output logic [2:0]       rsp_tuser,   // [2:0] field_tag
   output logic             rsp_tlast
);
   import irc_tag_pkg::*;

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;
   logic       out_valid_ff;
   result_type out_ff;
   result_type result;
   logic       out_free;
   logic       step;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign step       = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;

   irc_tag_parse #(
      .MAX_PARAMS (MAX_PARAMS)
   ) u_parse (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .line_byte (in_byte_ff),
      .line_end  (in_last_ff),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (out_free) begin
            out_valid_ff <= in_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (step) begin
         out_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'd0, out_ff.malformed, out_ff.prefix_done, out_ff.prefix_kind,
                        out_ff.param_index, out_ff.token_start, out_ff.byte_out};
   assign rsp_tuser  = out_ff.field_tag;
   assign rsp_tlast  = out_ff.last_out;

endmodule

`default_nettype wire

/* src/irc_tag_chk.sv */
// Port checker for the IRC message field tagger and its bind to the top level.
// Depends on irc_tag_pkg and irc_message_field_tagger_top.
`default_nettype none

module irc_tag_chk (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [23:0] rsp_tdata,
   input wire logic [2:0]  rsp_tuser,
   input wire logic        rsp_tlast
);
   import irc_tag_pkg::*;

   // A stalled result keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // A missing command is only reported on the last byte of a line.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[16] |-> rsp_tlast)
      else $error("malformed flag away from line end");

   // The prefix closes on a space separator with a known kind.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[15] |->
         rsp_tuser == TAG_SEP && rsp_tdata[7:0] == CHAR_SPACE &&
         (rsp_tdata[14:13] == KIND_SERVER || rsp_tdata[14:13] == KIND_NUH))
      else $error("bad prefix close");

   // Separators never start a token, and only middle parameters carry an index.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[8] || rsp_tdata[12:9] != 4'd0) |->
         rsp_tuser != TAG_SEP && (rsp_tdata[12:9] == 4'd0 || rsp_tuser == TAG_MIDDLE))
      else $error("inconsistent token marks");

endmodule

bind irc_message_field_tagger_top irc_tag_chk u_irc_tag_chk (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire
